// ----- design/bcp_pkg.sv -----
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared types, register indexes and the microprogram of the Bezier point
// generator.
// ----------------------------------------------------------------------------
package bcp_pkg;

    // Width of the stored step index
    localparam int STEP_W = 10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_START_X = 3'd0;
    localparam reg_idx_t REG_START_Y = 3'd1;
    localparam reg_idx_t REG_PULL1_X = 3'd2;
    localparam reg_idx_t REG_PULL1_Y = 3'd3;
    localparam reg_idx_t REG_PULL2_X = 3'd4;
    localparam reg_idx_t REG_PULL2_Y = 3'd5;
    localparam reg_idx_t REG_END_X   = 3'd6;
    localparam reg_idx_t REG_END_Y   = 3'd7;

    // Multiplier operand sources
    typedef enum logic [4:0] {
        SRC_K,
        SRC_M,
        SRC_KK,
        SRC_MM,
        SRC_T,
        SRC_THREE,
        SRC_W0,
        SRC_W1,
        SRC_W2,
        SRC_W3,
        SRC_PX0,
        SRC_PX1,
        SRC_PX2,
        SRC_PX3,
        SRC_PY0,
        SRC_PY1,
        SRC_PY2,
        SRC_PY3
    } src_t;

    // Product destinations
    typedef enum logic [3:0] {
        DST_NONE,
        DST_KK,
        DST_MM,
        DST_T,
        DST_W0,
        DST_W1,
        DST_W2,
        DST_W3,
        DST_PROD
    } dst_t;

    // Accumulator actions on the product register
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_CLR,
        ACC_X,
        ACC_Y
    } acc_t;

    // Jump conditions
    typedef enum logic [1:0] {
        JC_NEVER,
        JC_DIV_BUSY,
        JC_OUT_BUSY
    } cond_t;

    // Sequencer states
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    // Microprogram addresses that are jump targets
    localparam pc_t UC_DIV_WAIT = 5'd18;
    localparam pc_t UC_RETIRE   = 5'd19;

    // One control word
    typedef struct packed {
        src_t  src_a;
        src_t  src_b;
        dst_t  dst;
        acc_t  acc;
        logic  div_go;
        cond_t cond;
        pc_t   tgt;
        logic  fin;
    } ctrl_t;

    // Status fed back to the sequencer for its jumps
    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } seq_stat_t;

    localparam ctrl_t UC_NOP = '{
        src_a:  SRC_K,
        src_b:  SRC_K,
        dst:    DST_NONE,
        acc:    ACC_NONE,
        div_go: 1'b0,
        cond:   JC_NEVER,
        tgt:    '0,
        fin:    1'b0
    };

    // Microprogram: weights first, then the multiply-accumulate of the
    // control points, then the division by STEPS cubed.
    function automatic ctrl_t uc_word(input pc_t pc);
        ctrl_t w;
        w = UC_NOP;
        case (pc)
            5'd0:
            begin
                w.src_a = SRC_K;   w.src_b = SRC_K;     w.dst = DST_KK;
                w.acc   = ACC_CLR;
            end
            5'd1:
            begin
                w.src_a = SRC_M;   w.src_b = SRC_M;     w.dst = DST_MM;
            end
            5'd2:
            begin
                w.src_a = SRC_KK;  w.src_b = SRC_K;     w.dst = DST_W3;
            end
            5'd3:
            begin
                w.src_a = SRC_MM;  w.src_b = SRC_M;     w.dst = DST_W0;
            end
            5'd4:
            begin
                w.src_a = SRC_KK;  w.src_b = SRC_M;     w.dst = DST_T;
            end
            5'd5:
            begin
                w.src_a = SRC_T;   w.src_b = SRC_THREE; w.dst = DST_W2;
            end
            5'd6:
            begin
                w.src_a = SRC_MM;  w.src_b = SRC_K;     w.dst = DST_T;
            end
            5'd7:
            begin
                w.src_a = SRC_T;   w.src_b = SRC_THREE; w.dst = DST_W1;
            end
            5'd8:
            begin
                w.src_a = SRC_PX0; w.src_b = SRC_W0;    w.dst = DST_PROD;
            end
            5'd9:
            begin
                w.src_a = SRC_PY0; w.src_b = SRC_W0;    w.dst = DST_PROD;
                w.acc   = ACC_X;
            end
            5'd10:
            begin
                w.src_a = SRC_PX1; w.src_b = SRC_W1;    w.dst = DST_PROD;
                w.acc   = ACC_Y;
            end
            5'd11:
            begin
                w.src_a = SRC_PY1; w.src_b = SRC_W1;    w.dst = DST_PROD;
                w.acc   = ACC_X;
            end
            5'd12:
            begin
                w.src_a = SRC_PX2; w.src_b = SRC_W2;    w.dst = DST_PROD;
                w.acc   = ACC_Y;
            end
            5'd13:
            begin
                w.src_a = SRC_PY2; w.src_b = SRC_W2;    w.dst = DST_PROD;
                w.acc   = ACC_X;
            end
            5'd14:
            begin
                w.src_a = SRC_PX3; w.src_b = SRC_W3;    w.dst = DST_PROD;
                w.acc   = ACC_Y;
            end
            5'd15:
            begin
                w.src_a = SRC_PY3; w.src_b = SRC_W3;    w.dst = DST_PROD;
                w.acc   = ACC_X;
            end
            5'd16:
            begin
                w.acc = ACC_Y;
            end
            5'd17:
            begin
                w.div_go = 1'b1;
            end
            UC_DIV_WAIT:
            begin
                w.cond = JC_DIV_BUSY;
                w.tgt  = UC_DIV_WAIT;
            end
            UC_RETIRE:
            begin
                w.cond = JC_OUT_BUSY;
                w.tgt  = UC_RETIRE;
                w.fin  = 1'b1;
            end
            default:
            begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/cubic_bezier_point_generator_unit.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator_unit
// Cubic Bezier point generator: one curve point per tick, exact integers.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  -------------------------------
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//  in       in         in_valid / in_stall    restart
//  out      out        out_valid / out_stall  point_x, point_y, last
//
//  An item runs through sixteen steps of the one shared multiplier, a few
//  microprogram steps, and a reciprocal division before its result shows.
//  One item is in work at a time; in_stall is high while it runs.
//  The result waits in an output register, so a stalled output holds the
//  sequencer only at its final step.
//  Reset clears the control points to zero and the step index to zero.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator_unit
    import bcp_pkg::*;
#(
    parameter int STEPS      = 1000,
    parameter int COORD_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] point_x,
    output logic [COORD_BITS-1:0] point_y,
    output logic                  last
);

    localparam int NB    = $clog2(STEPS + 1);
    localparam int ACC_W = COORD_BITS + 3 * NB;

    logic [COORD_BITS-1:0] cfg_reg [8];
    logic [COORD_BITS-1:0] px [4];
    logic [COORD_BITS-1:0] py [4];

    logic [STEP_W-1:0]     step_idx_reg;
    logic [STEP_W-1:0]     step_idx_next;
    logic [STEP_W-1:0]     k_eff;
    logic                  is_last;
    logic                  last_pend_reg;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] point_x_reg;
    logic [COORD_BITS-1:0] point_y_reg;
    logic                  last_reg;

    logic                  accept;
    logic                  running;
    logic                  retire;
    ctrl_t                 ctrl;
    seq_stat_t             stat;
    logic [ACC_W-1:0]      acc_x;
    logic [ACC_W-1:0]      acc_y;
    logic                  div_busy;
    logic [COORD_BITS-1:0] quot_x;
    logic [COORD_BITS-1:0] quot_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign px[0] = cfg_reg[REG_START_X];
    assign px[1] = cfg_reg[REG_PULL1_X];
    assign px[2] = cfg_reg[REG_PULL2_X];
    assign px[3] = cfg_reg[REG_END_X];
    assign py[0] = cfg_reg[REG_START_Y];
    assign py[1] = cfg_reg[REG_PULL1_Y];
    assign py[2] = cfg_reg[REG_PULL2_Y];
    assign py[3] = cfg_reg[REG_END_Y];

    assign in_stall = running;
    assign accept   = in_valid && !in_stall;

    // Restart, or a stray index, begins the curve again
    always_comb
    begin
        if (restart || (step_idx_reg > STEP_W'(STEPS)))
        begin
            k_eff = '0;
        end
        else
        begin
            k_eff = step_idx_reg;
        end
        is_last       = (k_eff == STEP_W'(STEPS));
        step_idx_next = is_last ? '0 : (k_eff + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_idx_reg <= '0;
        end
        else if (accept)
        begin
            step_idx_reg <= step_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_pend_reg <= is_last;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_valid_reg && out_stall;

    bcp_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .stat    (stat),
        .ctrl    (ctrl),
        .running (running),
        .retire  (retire)
    );

    bcp_datapath #(
        .STEPS      (STEPS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .load_k (accept),
        .k_in   (k_eff[NB-1:0]),
        .ctrl   (ctrl),
        .px     (px),
        .py     (py),
        .acc_x  (acc_x),
        .acc_y  (acc_y)
    );

    bcp_divider #(
        .STEPS      (STEPS),
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.div_go),
        .num_x  (acc_x),
        .num_y  (acc_y),
        .busy   (div_busy),
        .quot_x (quot_x),
        .quot_y (quot_y)
    );

    // Output register: load on retire, drop once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (retire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            point_x_reg <= quot_x;
            point_y_reg <= quot_y;
            last_reg    <= last_pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign last      = last_reg;

endmodule

// ----- design/bcp_sequencer.sv -----
// ----------------------------------------------------------------------------
// bcp_sequencer
// Step counter and microprogram table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module bcp_sequencer
    import bcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  seq_stat_t stat,
    output ctrl_t     ctrl,
    output logic      running,
    output logic      retire
);

    seq_state_t state_reg;
    seq_state_t state_next;
    pc_t        pc_reg;
    pc_t        pc_next;
    ctrl_t      word;
    logic       taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        word = uc_word(pc_reg);
        case (word.cond)
            JC_DIV_BUSY: taken = stat.div_busy;
            JC_OUT_BUSY: taken = stat.out_busy;
            default:     taken = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ctrl       = UC_NOP;
        retire     = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SEQ_RUN;
                    pc_next    = '0;
                end
            end
            SEQ_RUN:
            begin
                ctrl = word;
                if (taken)
                begin
                    pc_next = word.tgt;
                end
                else if (word.fin)
                begin
                    state_next = SEQ_IDLE;
                    retire     = 1'b1;
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign running = (state_reg == SEQ_RUN);

endmodule

// ----- design/bcp_datapath.sv -----
// ----------------------------------------------------------------------------
// bcp_datapath
// Shared multiplier, weight registers and the two coordinate accumulators.
// ----------------------------------------------------------------------------
module bcp_datapath
    import bcp_pkg::*;
#(
    parameter int STEPS      = 1000,
    parameter int COORD_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_k,
    input  logic [$clog2(STEPS+1)-1:0] k_in,
    input  ctrl_t                 ctrl,
    input  logic [COORD_BITS-1:0] px [4],
    input  logic [COORD_BITS-1:0] py [4],
    output logic [COORD_BITS+3*$clog2(STEPS+1)-1:0] acc_x,
    output logic [COORD_BITS+3*$clog2(STEPS+1)-1:0] acc_y
);

    localparam int NB    = $clog2(STEPS + 1);
    localparam int KK_W  = 2 * NB;
    localparam int T_W   = 3 * NB;
    localparam int W_W   = 3 * NB + 2;
    localparam int OPW   = (W_W > COORD_BITS) ? W_W : COORD_BITS;
    localparam int ACC_W = COORD_BITS + 3 * NB;

    logic [NB-1:0]    k_reg;
    logic [NB-1:0]    m_reg;
    logic [KK_W-1:0]  kk_reg;
    logic [KK_W-1:0]  mm_reg;
    logic [T_W-1:0]   t_reg;
    logic [W_W-1:0]   w0_reg;
    logic [W_W-1:0]   w1_reg;
    logic [W_W-1:0]   w2_reg;
    logic [W_W-1:0]   w3_reg;
    logic [ACC_W-1:0] prod_reg;
    logic [ACC_W-1:0] acc_x_reg;
    logic [ACC_W-1:0] acc_y_reg;

    logic [OPW-1:0]   op_a;
    logic [OPW-1:0]   op_b;
    logic [2*OPW-1:0] product;

    function automatic logic [OPW-1:0] operand(input src_t s);
        logic [OPW-1:0] v;
        v = '0;
        case (s)
            SRC_K:     v = OPW'(k_reg);
            SRC_M:     v = OPW'(m_reg);
            SRC_KK:    v = OPW'(kk_reg);
            SRC_MM:    v = OPW'(mm_reg);
            SRC_T:     v = OPW'(t_reg);
            SRC_THREE: v = OPW'(3);
            SRC_W0:    v = OPW'(w0_reg);
            SRC_W1:    v = OPW'(w1_reg);
            SRC_W2:    v = OPW'(w2_reg);
            SRC_W3:    v = OPW'(w3_reg);
            SRC_PX0:   v = OPW'(px[0]);
            SRC_PX1:   v = OPW'(px[1]);
            SRC_PX2:   v = OPW'(px[2]);
            SRC_PX3:   v = OPW'(px[3]);
            SRC_PY0:   v = OPW'(py[0]);
            SRC_PY1:   v = OPW'(py[1]);
            SRC_PY2:   v = OPW'(py[2]);
            SRC_PY3:   v = OPW'(py[3]);
            default:   v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        op_a    = operand(ctrl.src_a);
        op_b    = operand(ctrl.src_b);
        product = op_a * op_b;
    end

    // Step index and its complement, taken when an item is accepted
    always_ff @(posedge clk)
    begin
        if (load_k)
        begin
            k_reg <= k_in;
            m_reg <= NB'(STEPS) - k_in;
        end
    end

    // Each product lands in one register; the values are known to fit
    always_ff @(posedge clk)
    begin
        case (ctrl.dst)
            DST_KK:   kk_reg   <= product[KK_W-1:0];
            DST_MM:   mm_reg   <= product[KK_W-1:0];
            DST_T:    t_reg    <= product[T_W-1:0];
            DST_W0:   w0_reg   <= product[W_W-1:0];
            DST_W1:   w1_reg   <= product[W_W-1:0];
            DST_W2:   w2_reg   <= product[W_W-1:0];
            DST_W3:   w3_reg   <= product[W_W-1:0];
            DST_PROD: prod_reg <= product[ACC_W-1:0];
            default:  ;
        endcase
    end

    // Clear both axes, or add last cycle's product into one axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else
        begin
            case (ctrl.acc)
                ACC_CLR:
                begin
                    acc_x_reg <= '0;
                    acc_y_reg <= '0;
                end
                ACC_X:   acc_x_reg <= acc_x_reg + prod_reg;
                ACC_Y:   acc_y_reg <= acc_y_reg + prod_reg;
                default: ;
            endcase
        end
    end

    assign acc_x = acc_x_reg;
    assign acc_y = acc_y_reg;

endmodule

// ----- design/bcp_divider.sv -----
// ----------------------------------------------------------------------------
// bcp_divider
// Two-lane division by the constant STEPS cubed: a reciprocal multiply gives
// an estimate at most one below the quotient, and one compare corrects it.
// ----------------------------------------------------------------------------
module bcp_divider
    import bcp_pkg::*;
#(
    parameter int STEPS      = 1000,
    parameter int COORD_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS+3*$clog2(STEPS+1)-1:0] num_x,
    input  logic [COORD_BITS+3*$clog2(STEPS+1)-1:0] num_y,
    output logic                  busy,
    output logic [COORD_BITS-1:0] quot_x,
    output logic [COORD_BITS-1:0] quot_y
);

    localparam int NB    = $clog2(STEPS + 1);
    localparam int ACC_W = COORD_BITS + 3 * NB;
    localparam longint unsigned DEN = 64'(STEPS) * 64'(STEPS) * 64'(STEPS);
    localparam int DEN_W = $clog2(DEN + 64'd1);
    // Numerator is below 2^(COORD_BITS + DEN_W), so its top bits from SH fit
    localparam int SH    = DEN_W - 2;
    localparam int HI_W  = COORD_BITS + 2;
    localparam int RS    = COORD_BITS + 4;
    localparam int RCP_W = COORD_BITS + 4;
    localparam int EST_W = HI_W + RCP_W;
    localparam int QD_W  = COORD_BITS + DEN_W;
    localparam logic [DEN_W-1:0] DEN_V = DEN_W'(DEN);
    localparam logic [RCP_W-1:0] RCP_V = RCP_W'((64'd1 << (RS + SH)) / DEN);

    logic [ACC_W-1:0]      num_x_reg;
    logic [ACC_W-1:0]      num_y_reg;
    logic [EST_W-1:0]      est_x_reg;
    logic [EST_W-1:0]      est_y_reg;
    logic [COORD_BITS-1:0] qe_x_reg;
    logic [COORD_BITS-1:0] qe_y_reg;
    logic [QD_W-1:0]       qd_x_reg;
    logic [QD_W-1:0]       qd_y_reg;
    logic [COORD_BITS-1:0] qx_reg;
    logic [COORD_BITS-1:0] qy_reg;
    logic                  busy_reg;
    logic                  phase_reg;

    logic [COORD_BITS-1:0] qe_x_next;
    logic [COORD_BITS-1:0] qe_y_next;
    logic [ACC_W-1:0]      rem_x;
    logic [ACC_W-1:0]      rem_y;

    always_comb
    begin
        qe_x_next = est_x_reg[RS +: COORD_BITS];
        qe_y_next = est_y_reg[RS +: COORD_BITS];
        rem_x     = num_x_reg - ACC_W'(qd_x_reg);
        rem_y     = num_y_reg - ACC_W'(qd_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            phase_reg <= 1'b1;
            if (phase_reg)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_x_reg <= num_x;
            num_y_reg <= num_y;
            est_x_reg <= EST_W'(num_x[SH +: HI_W]) * EST_W'(RCP_V);
            est_y_reg <= EST_W'(num_y[SH +: HI_W]) * EST_W'(RCP_V);
        end
        else if (busy_reg && !phase_reg)
        begin
            qe_x_reg <= qe_x_next;
            qe_y_reg <= qe_y_next;
            qd_x_reg <= QD_W'(qe_x_next) * QD_W'(DEN_V);
            qd_y_reg <= QD_W'(qe_y_next) * QD_W'(DEN_V);
        end
        else if (busy_reg)
        begin
            // Estimate is never high and at most one low
            qx_reg <= qe_x_reg + COORD_BITS'(rem_x >= ACC_W'(DEN_V));
            qy_reg <= qe_y_reg + COORD_BITS'(rem_y >= ACC_W'(DEN_V));
        end
    end

    assign busy   = busy_reg;
    assign quot_x = qx_reg;
    assign quot_y = qy_reg;

endmodule

// ----- design/bcp_checker.sv -----
// ----------------------------------------------------------------------------
// bcp_checker
// Port-level checks on the Bezier point generator, bound to the top level.
// ----------------------------------------------------------------------------
module bcp_checker
    import bcp_pkg::*;
#(
    parameter int COORD_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic                  last
);

    logic [COORD_BITS-1:0] end_x_reg;
    logic [COORD_BITS-1:0] end_y_reg;

    // Track the curve end point from configuration transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_x_reg <= '0;
            end_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_END_X)
            begin
                end_x_reg <= cfg_data;
            end
            if (cfg_index == REG_END_Y)
            begin
                end_y_reg <= cfg_data;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(point_x) && $stable(point_y) && $stable(last)))
        else $error("stalled result changed");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not held off after a transfer");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in work");

    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> ((point_x == end_x_reg) && (point_y == end_y_reg)))
        else $error("final point differs from the curve end");

endmodule

bind cubic_bezier_point_generator_unit bcp_checker #(
    .COORD_BITS (COORD_BITS)
) u_bcp_checker (.*);
